// ===== hdl/spas_pkg.sv =====
// Shared types and constants for the sprite animation phase selector.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package spas_pkg;

    // Table depth and derived widths
    localparam int MAX_PHASES = 64;
    localparam int PH_AW      = $clog2(MAX_PHASES);
    localparam int CNT_W      = 7;

    // Field widths
    localparam int TIME_W   = 48;
    localparam int COORD_W  = 16;
    localparam int Z_W      = 4;
    localparam int DUR_W    = 16;
    localparam int FRAME_W  = 8;
    localparam int TOTAL_W  = 22;
    localparam int HASH_W   = 22;
    localparam int OFF_W    = 31;

    // Shared divider widths
    localparam int DIV_W    = 49;
    localparam int REM_W    = 23;
    localparam int DCNT_W   = 6;

    localparam int TICK_MS      = 500;
    localparam int RANDOM_START = 255;

    // APB register map (word index)
    localparam int          ADDR_W          = 5;
    localparam logic [2:0]  REG_FRAME_COUNT = 3'd0;
    localparam logic [2:0]  REG_PHASE_COUNT = 3'd1;
    localparam logic [2:0]  REG_SYNC_MODE   = 3'd2;
    localparam logic [2:0]  REG_START_FRAME = 3'd3;
    localparam logic [2:0]  REG_PING_PONG   = 3'd4;
    localparam logic [2:0]  REG_TOTAL_DUR   = 3'd5;

    // Word kinds on s_tuser
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MAIN,
        ST_DIV,
        ST_POST,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_DONE
    } state_t;

    // What the divider result is used for
    typedef enum logic [2:0] {
        DOP_START,
        DOP_TICK,
        DOP_RAW,
        DOP_SPAN,
        DOP_FINAL
    } dop_t;

endpackage

`default_nettype wire

// ===== hdl/sprite_animation_phase_select.sv =====
// Operation: a load word is written at its accepting edge, no result. A query uses one shared
// restoring divider (1 bit/cycle, up to 49 steps per use) and a read and a compare state per
// entry walked. Worst case: table query with random start, 22 + 49 divider steps, 64 entries
// walked, 9-step final reduction. No table: a tick division and a frame reduction.
// Throughput: loads back to back; a query holds s_tready low until its result is offered.
// Sync active-low reset restores register defaults, not the table. Depends on spas_pkg.
`default_nettype none

module sprite_animation_phase_select (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // APB configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [spas_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // Input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // tdata: entry_index[5:0], duration_min[21:6], duration_max[37:22], time_ms[85:38],
    //        tile_x[101:86], tile_y[117:102], tile_z[121:118], zero pad [127:122]
    input  wire logic [127:0]                s_tdata,
    // tuser: kind[0]
    input  wire logic                        s_tuser,
    // Result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // tdata: phase[7:0]
    output logic [7:0]                       m_tdata
);
    import spas_pkg::*;

    // Input fields
    logic [5:0]         in_idx;
    logic [DUR_W-1:0]   in_dmin;
    logic [DUR_W-1:0]   in_dmax;
    logic [TIME_W-1:0]  in_time;
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [Z_W-1:0]     in_z;

    assign in_idx  = s_tdata[5:0];
    assign in_dmin = s_tdata[21:6];
    assign in_dmax = s_tdata[37:22];
    assign in_time = s_tdata[85:38];
    assign in_x    = s_tdata[101:86];
    assign in_y    = s_tdata[117:102];
    assign in_z    = s_tdata[121:118];

    // Configuration registers
    logic [FRAME_W-1:0] frame_count_reg;
    logic [CNT_W-1:0]   phase_count_reg;
    logic               sync_mode_reg;
    logic [FRAME_W-1:0] start_frame_reg;
    logic               ping_pong_reg;
    logic [TOTAL_W-1:0] total_dur_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= FRAME_W'(1);
            phase_count_reg <= '0;
            sync_mode_reg   <= 1'b1;
            start_frame_reg <= '0;
            ping_pong_reg   <= 1'b0;
            total_dur_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_COUNT: frame_count_reg <= pwdata[FRAME_W-1:0];
                REG_PHASE_COUNT: phase_count_reg <= pwdata[CNT_W-1:0];
                REG_SYNC_MODE:   sync_mode_reg   <= pwdata[0];
                REG_START_FRAME: start_frame_reg <= pwdata[FRAME_W-1:0];
                REG_PING_PONG:   ping_pong_reg   <= pwdata[0];
                REG_TOTAL_DUR:   total_dur_reg   <= pwdata[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_COUNT: prdata = 32'(frame_count_reg);
            REG_PHASE_COUNT: prdata = 32'(phase_count_reg);
            REG_SYNC_MODE:   prdata = 32'(sync_mode_reg);
            REG_START_FRAME: prdata = 32'(start_frame_reg);
            REG_PING_PONG:   prdata = 32'(ping_pong_reg);
            REG_TOTAL_DUR:   prdata = 32'(total_dur_reg);
            default:         prdata = '0;
        endcase
    end

    // Derived settings
    logic [FRAME_W-1:0] frames_w;
    logic [CNT_W-1:0]   count_w;
    logic               async_w;
    logic [8:0]         cycle_w;
    logic [REM_W-1:0]   span_w;

    assign frames_w = (frame_count_reg == '0) ? FRAME_W'(1) : frame_count_reg;
    assign count_w  = (phase_count_reg > CNT_W'(MAX_PHASES)) ? CNT_W'(MAX_PHASES)
                                                             : phase_count_reg;
    assign async_w  = (count_w != '0) && !sync_mode_reg;
    assign cycle_w  = {frames_w, 1'b0} - 9'd2;
    assign span_w   = ping_pong_reg ? {total_dur_reg, 1'b0} : {1'b0, total_dur_reg};

    // State and datapath registers
    state_t             state_reg,   state_next;
    dop_t               dop_reg,     dop_next;
    logic [TIME_W-1:0]  t_reg,       t_next;
    logic [HASH_W-1:0]  hash_reg,    hash_next;
    logic [OFF_W-1:0]   off_reg,     off_next;
    logic [FRAME_W-1:0] start_reg,   start_next;
    logic [FRAME_W-1:0] result_reg,  result_next;
    logic [REM_W-1:0]   elap_reg,    elap_next;
    logic [CNT_W-1:0]   p_reg,       p_next;
    logic [DIV_W-1:0]   dvd_reg,     dvd_next;
    logic [REM_W-1:0]   rem_reg,     rem_next;
    logic [REM_W-1:0]   den_reg,     den_next;
    logic [DCNT_W-1:0]  dcnt_reg,    dcnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [7:0]         m_tdata_reg,  m_tdata_next;

    logic s_acc;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Duration table
    logic [DUR_W-1:0] dur_mem [MAX_PHASES];
    logic [DUR_W-1:0] dur_rd_reg;
    logic [DUR_W:0]   dsum;
    logic             load_ok;

    assign dsum    = {1'b0, in_dmin} + {1'b0, in_dmax};
    assign load_ok = ({1'b0, in_idx} < CNT_W'(MAX_PHASES));

    always_ff @(posedge aclk) begin
        if (s_acc && (s_tuser == KIND_LOAD) && load_ok) begin
            dur_mem[PH_AW'(in_idx)] <= dsum[DUR_W:1];
        end
        if (state_reg == ST_WALK_RD) begin
            dur_rd_reg <= dur_mem[p_reg[PH_AW-1:0]];
        end
    end

    // Tile hash 17x + 31y + 7z by shifts and adds
    logic [HASH_W-1:0] hx, hy, hz, hash_in;
    logic [OFF_W-1:0]  h31, off500;

    assign hx      = HASH_W'(in_x);
    assign hy      = HASH_W'(in_y);
    assign hz      = HASH_W'(in_z);
    assign hash_in = (hx << 4) + hx + (hy << 5) - hy + (hz << 3) - hz;
    assign h31     = OFF_W'(hash_reg);
    assign off500  = (h31 << 9) - (h31 << 3) - (h31 << 2);

    // Shared restoring divider step
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    // Helper values for the sequencer
    logic [DIV_W-1:0] shifted;
    logic [DIV_W-1:0] raw;
    logic [8:0]       mval;
    logic [8:0]       psum;
    logic             hit;

    assign shifted = {1'b0, t_reg} + DIV_W'(off_reg);
    assign raw     = {1'b0, dvd_reg[TIME_W-1:0]} + DIV_W'(start_reg);
    assign mval    = rem_reg[8:0];
    assign psum    = 9'(p_reg) + 9'(start_reg);
    assign hit     = (elap_reg < REM_W'(dur_rd_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dop_reg     <= dop_next;
        t_reg       <= t_next;
        hash_reg    <= hash_next;
        off_reg     <= off_next;
        start_reg   <= start_next;
        result_reg  <= result_next;
        elap_reg    <= elap_next;
        p_reg       <= p_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        dcnt_reg    <= dcnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser == KIND_QUERY)) state_next = ST_START;
            end
            ST_START: begin
                priority if (frames_w <= FRAME_W'(1)) state_next = ST_DONE;
                else if ((start_frame_reg == FRAME_W'(RANDOM_START)) && async_w)
                    state_next = ST_DIV;
                else if (start_frame_reg != '0) state_next = ST_DIV;
                else state_next = ST_MAIN;
            end
            ST_MAIN: begin
                priority if (count_w == '0) state_next = ST_DIV;
                else if (total_dur_reg == '0) state_next = ST_DONE;
                else state_next = ST_DIV;
            end
            ST_DIV: begin
                if (dcnt_reg == DCNT_W'(1)) state_next = ST_POST;
            end
            ST_POST: begin
                unique case (dop_reg)
                    DOP_START: state_next = ST_MAIN;
                    DOP_TICK:  state_next = ST_DIV;
                    DOP_RAW:   state_next = ST_DONE;
                    DOP_SPAN:  state_next = ST_WALK_RD;
                    DOP_FINAL: state_next = ST_DONE;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_WALK_RD: begin
                state_next = (p_reg == count_w) ? ST_DONE : ST_WALK_CMP;
            end
            ST_WALK_CMP: begin
                state_next = hit ? ST_DIV : ST_WALK_RD;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        dop_next      = dop_reg;
        t_next        = t_reg;
        hash_next     = hash_reg;
        off_next      = off_reg;
        start_next    = start_reg;
        result_next   = result_reg;
        elap_next     = elap_reg;
        p_next        = p_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        dcnt_next     = dcnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    t_next    = in_time;
                    hash_next = hash_in;
                end
            end
            ST_START: begin
                off_next   = async_w ? off500 : '0;
                start_next = '0;
                rem_next   = '0;
                den_next   = REM_W'(frames_w);
                dop_next   = DOP_START;
                priority if (frames_w <= FRAME_W'(1)) begin
                    result_next = '0;
                end else if ((start_frame_reg == FRAME_W'(RANDOM_START)) && async_w) begin
                    dvd_next  = {hash_reg, (DIV_W - HASH_W)'(0)};
                    dcnt_next = DCNT_W'(HASH_W);
                end else begin
                    dvd_next  = {start_frame_reg, (DIV_W - FRAME_W)'(0)};
                    dcnt_next = DCNT_W'(FRAME_W);
                end
            end
            ST_MAIN: begin
                rem_next = '0;
                priority if (count_w == '0) begin
                    dvd_next  = {t_reg, 1'b0};
                    den_next  = REM_W'(TICK_MS);
                    dcnt_next = DCNT_W'(TIME_W);
                    dop_next  = DOP_TICK;
                end else if (total_dur_reg == '0) begin
                    result_next = start_reg;
                end else begin
                    dvd_next  = shifted;
                    den_next  = span_w;
                    dcnt_next = DCNT_W'(DIV_W);
                    dop_next  = DOP_SPAN;
                end
            end
            ST_DIV: begin
                rem_next  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                dvd_next  = {dvd_reg[DIV_W-2:0], ge};
                dcnt_next = dcnt_reg - DCNT_W'(1);
            end
            ST_POST: begin
                unique case (dop_reg)
                    DOP_START: start_next = rem_reg[FRAME_W-1:0];
                    DOP_TICK: begin
                        // raw tick count plus start, reduced by period or frame count
                        dvd_next  = raw;
                        rem_next  = '0;
                        den_next  = ping_pong_reg ? REM_W'(cycle_w) : REM_W'(frames_w);
                        dcnt_next = DCNT_W'(DIV_W);
                        dop_next  = DOP_RAW;
                    end
                    DOP_RAW: begin
                        result_next = (ping_pong_reg && (mval >= 9'(frames_w)))
                                    ? 8'(cycle_w - mval) : mval[7:0];
                    end
                    DOP_SPAN: begin
                        // fold the return leg of a bounce
                        elap_next = (ping_pong_reg && (rem_reg >= REM_W'(total_dur_reg)))
                                  ? span_w - rem_reg : rem_reg;
                        p_next    = '0;
                    end
                    DOP_FINAL: result_next = rem_reg[FRAME_W-1:0];
                    default: ;
                endcase
            end
            ST_WALK_RD: begin
                // table exhausted: fall back to the start phase
                if (p_reg == count_w) result_next = start_reg;
            end
            ST_WALK_CMP: begin
                if (hit) begin
                    dvd_next  = {psum, (DIV_W - 9)'(0)};
                    rem_next  = '0;
                    den_next  = REM_W'(frames_w);
                    dcnt_next = DCNT_W'(9);
                    dop_next  = DOP_FINAL;
                end else begin
                    elap_next = elap_reg - REM_W'(dur_rd_reg);
                    p_next    = p_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/spas_checker.sv =====
// Port-level checker for sprite_animation_phase_select, bound to the top level.
// Depends on spas_pkg.
`default_nettype none

module spas_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    import spas_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    // phase is always below the frame count, so never 255
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != 8'hFF))
        else $error("phase out of range");

    // a query occupies the sequencer
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == KIND_QUERY)) |=> !s_tready)
        else $error("ready after query accept");

    // a load word leaves the port ready again in the next cycle
    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == KIND_LOAD)) |=> s_tready)
        else $error("not ready after load word");

endmodule

bind sprite_animation_phase_select spas_checker u_spas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
